>>> sv/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg: shared types and constants for the HTTP response parser
// Phase codes, byte kinds, header ids and the parser state record.
// ----------------------------------------------------------------------------
package hrsp_pkg;

	localparam int LEN_W = 32;

	localparam logic [4:0] PH_VER      = 5'd0;
	localparam logic [4:0] PH_SP1      = 5'd1;
	localparam logic [4:0] PH_CODE     = 5'd2;
	localparam logic [4:0] PH_SP2      = 5'd3;
	localparam logic [4:0] PH_PHRASE   = 5'd4;
	localparam logic [4:0] PH_HSTART   = 5'd5;
	localparam logic [4:0] PH_HEND_LF  = 5'd6;
	localparam logic [4:0] PH_HNAME    = 5'd7;
	localparam logic [4:0] PH_HSP      = 5'd8;
	localparam logic [4:0] PH_HVAL     = 5'd9;
	localparam logic [4:0] PH_LEN      = 5'd10;
	localparam logic [4:0] PH_LEN_LF   = 5'd11;
	localparam logic [4:0] PH_BODY     = 5'd12;
	localparam logic [4:0] PH_CSIZE    = 5'd13;
	localparam logic [4:0] PH_CSIZE_LF = 5'd14;
	localparam logic [4:0] PH_CDATA    = 5'd15;
	localparam logic [4:0] PH_CCR      = 5'd16;
	localparam logic [4:0] PH_CLF      = 5'd17;
	localparam logic [4:0] PH_TCR      = 5'd18;
	localparam logic [4:0] PH_TLF      = 5'd19;
	localparam logic [4:0] PH_DONE     = 5'd20;
	localparam logic [4:0] PH_ERR      = 5'd21;

	localparam logic [2:0] K_STATUS = 3'd0;
	localparam logic [2:0] K_HNAME  = 3'd1;
	localparam logic [2:0] K_HVAL   = 3'd2;
	localparam logic [2:0] K_EOL    = 3'd3;
	localparam logic [2:0] K_BODY   = 3'd4;
	localparam logic [2:0] K_CHUNK  = 3'd5;
	localparam logic [2:0] K_IGN    = 3'd6;
	localparam logic [2:0] K_ERR    = 3'd7;

	localparam logic [2:0] H_NONE = 3'd0;
	localparam logic [2:0] H_LEN  = 3'd1;
	localparam logic [2:0] H_TE   = 3'd6;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef struct packed {
		logic [4:0]       phase;
		logic [4:0]       mpos;
		logic [5:0]       cand;
		logic [2:0]       hdr;
		logic [LEN_W-1:0] acc;
		logic [LEN_W-1:0] rem;
		logic             chunked;
		logic             first_chunk;
		logic             cmatch;
		logic             saw_cr;
		logic [9:0]       code;
		logic [7:0]       ver;
	} state_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [2:0]       hid;
		logic [7:0]       body;
		logic [9:0]       code;
		logic [3:0]       vmaj;
		logic [3:0]       vmin;
		logic [LEN_W-1:0] lval;
		logic             lvalid;
		logic             done;
		logic             err;
	} result_t;

	function automatic state_t reset_state();
		state_t s;
		s = '0;
		s.phase = PH_VER;
		s.cand = 6'h3F;
		s.first_chunk = 1'b1;
		s.cmatch = 1'b1;
		return s;
	endfunction

	function automatic logic [4:0] hdr_len(input int i);
		case (i)
			0: return 5'd14;
			1: return 5'd12;
			2: return 5'd10;
			3: return 5'd4;
			4: return 5'd6;
			default: return 5'd17;
		endcase
	endfunction

	// expected character of known header i at position p, 0 past its end
	function automatic logic [7:0] hdr_char(input int i, input logic [4:0] p);
		logic [135:0] t;
		logic [4:0]   n;
		n = hdr_len(i);
		case (i)
			0: t = 136'("Content-Length");
			1: t = 136'("Content-Type");
			2: t = 136'("Connection");
			3: t = 136'("Date");
			4: t = 136'("Server");
			default: t = 136'("Transfer-Encoding");
		endcase
		// first character sits in the highest used byte
		if (p < n) return t[8*(int'(n) - 1 - int'(p)) +: 8];
		return 8'h00;
	endfunction

	function automatic logic [7:0] proto_char(input logic [4:0] p);
		case (p)
			5'd0: return "H";
			5'd1: return "T";
			5'd2: return "T";
			5'd3: return "P";
			default: return "/";
		endcase
	endfunction

	function automatic logic [7:0] chunk_char(input logic [4:0] p);
		case (p)
			5'd0: return "c";
			5'd1: return "h";
			5'd2: return "u";
			5'd3: return "n";
			5'd4: return "k";
			5'd5: return "e";
			default: return "d";
		endcase
	endfunction

endpackage

>>> sv/hrsp_step.sv
// ----------------------------------------------------------------------------
// hrsp_step: next-state and result logic for one byte
// Pure combinational update of the parser state from one input byte.
// ----------------------------------------------------------------------------
module hrsp_step (
	input  hrsp_pkg::state_t  cur,
	input  logic [7:0]        data_byte,
	input  logic              start_message,
	output hrsp_pkg::state_t  nxt,
	output hrsp_pkg::result_t res
);

	localparam int W = hrsp_pkg::LEN_W;
	localparam logic [W-1:0] MAXV = '1;
	localparam logic [W-1:0] DEC_LIM = MAXV / 10;
	localparam logic [3:0]   DEC_REM = 4'(MAXV % 10);

	always_comb begin
		hrsp_pkg::state_t s;
		logic [7:0] b;
		logic fail, isdig;
		logic [2:0] kind, hid;
		logic [7:0] body;
		logic [W-1:0] lv;
		logic lvalid, done;
		logic [1:0] r;
		logic [3:0] dig, hx;
		logic hxok;
		logic [W+3:0] mul;

		b = data_byte;
		s = start_message ? hrsp_pkg::reset_state() : cur;
		fail = 1'b0; kind = hrsp_pkg::K_STATUS; hid = hrsp_pkg::H_NONE;
		body = '0; lv = '0; lvalid = 1'b0; done = 1'b0; r = 2'd0;
		isdig = (b >= "0") && (b <= "9");
		dig = 4'(b - "0");
		hxok = 1'b1; hx = dig;
		if (isdig) hx = dig;
		else if (b >= "A" && b <= "F") hx = 4'(b - "A" + 8'd10);
		else if (b >= "a" && b <= "f") hx = 4'(b - "a" + 8'd10);
		else hxok = 1'b0;
		mul = (W+4)'(s.acc) * (W+4)'(10) + (W+4)'(dig);

		if (s.phase == hrsp_pkg::PH_SP1 && b != " ") s.phase = hrsp_pkg::PH_CODE;
		if (s.phase == hrsp_pkg::PH_SP2 && b != " ") s.phase = hrsp_pkg::PH_PHRASE;
		if (s.phase == hrsp_pkg::PH_HSP && b != " ")
			s.phase = (s.hdr == hrsp_pkg::H_LEN) ? hrsp_pkg::PH_LEN : hrsp_pkg::PH_HVAL;
		if (s.phase == hrsp_pkg::PH_HSTART && b != hrsp_pkg::CH_CR)
			s.phase = hrsp_pkg::PH_HNAME;

		// CR LF line scan for phrase and text values
		if (s.phase == hrsp_pkg::PH_PHRASE || s.phase == hrsp_pkg::PH_HVAL) begin
			if (s.saw_cr) begin
				if (b == hrsp_pkg::CH_LF) begin
					s.saw_cr = 1'b0; r = 2'd2;
				end else begin
					s.cmatch = 1'b0;
					if (b == hrsp_pkg::CH_CR) r = 2'd1;
					else s.saw_cr = 1'b0;
				end
			end else if (b == hrsp_pkg::CH_CR) begin
				s.saw_cr = 1'b1; r = 2'd1;
			end
		end

		case (s.phase)
			hrsp_pkg::PH_VER: begin
				if (s.mpos < 5'd5) fail = (b != hrsp_pkg::proto_char(s.mpos));
				else if (s.mpos == 5'd6) fail = (b != ".");
				else if (!isdig) fail = 1'b1;
				else if (s.mpos == 5'd5) s.ver = {dig, 4'd0};
				else begin
					s.ver = {s.ver[7:4], dig};
					s.phase = hrsp_pkg::PH_SP1;
				end
				s.mpos = s.mpos + 5'd1;
				if (s.phase == hrsp_pkg::PH_SP1) begin
					s.mpos = '0; s.acc = '0;
				end
			end
			hrsp_pkg::PH_SP1, hrsp_pkg::PH_SP2: ;
			hrsp_pkg::PH_CODE: begin
				if (!isdig) fail = 1'b1;
				else begin
					s.acc = mul[W-1:0];
					s.mpos = s.mpos + 5'd1;
					if (s.mpos >= 5'd3) begin
						s.code = s.acc[9:0]; s.acc = '0; s.mpos = '0;
						s.saw_cr = 1'b0; s.phase = hrsp_pkg::PH_SP2;
					end
				end
			end
			hrsp_pkg::PH_PHRASE: begin
				if (r != 2'd0) kind = hrsp_pkg::K_EOL;
				if (r == 2'd2) begin
					s.phase = hrsp_pkg::PH_HSTART; s.mpos = '0; s.cand = 6'h3F;
					s.hdr = '0; s.saw_cr = 1'b0;
				end
			end
			hrsp_pkg::PH_HSTART: begin
				kind = hrsp_pkg::K_EOL; s.phase = hrsp_pkg::PH_HEND_LF;
			end
			hrsp_pkg::PH_HEND_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_EOL;
					if (s.chunked) begin
						s.rem = '0; s.first_chunk = 1'b1; s.acc = '0;
						s.phase = hrsp_pkg::PH_CSIZE;
					end else if (s.rem == '0) begin
						done = 1'b1; s.phase = hrsp_pkg::PH_DONE;
					end else s.phase = hrsp_pkg::PH_BODY;
				end
			end
			hrsp_pkg::PH_HNAME: begin
				kind = hrsp_pkg::K_HNAME;
				if (b == ":") begin
					s.hdr = '0;
					for (int i = 0; i < 6; i++)
						if (s.cand[i] && hrsp_pkg::hdr_len(i) == s.mpos) s.hdr = 3'(i + 1);
					hid = s.hdr; s.acc = '0; s.mpos = '0; s.cmatch = 1'b1;
					s.saw_cr = 1'b0; s.phase = hrsp_pkg::PH_HSP;
				end else if (b == hrsp_pkg::CH_CR || b == hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					for (int i = 0; i < 6; i++)
						if (s.mpos >= hrsp_pkg::hdr_len(i) || hrsp_pkg::hdr_char(i, s.mpos) != b)
							s.cand[i] = 1'b0;
					if (s.mpos < 5'd31) s.mpos = s.mpos + 5'd1;
				end
			end
			hrsp_pkg::PH_HSP: begin
				kind = hrsp_pkg::K_HVAL; hid = s.hdr;
			end
			hrsp_pkg::PH_HVAL: begin
				hid = s.hdr;
				if (r == 2'd0) begin
					kind = hrsp_pkg::K_HVAL;
					if (s.hdr == hrsp_pkg::H_TE) begin
						if (s.mpos < 5'd7 && b == hrsp_pkg::chunk_char(s.mpos))
							s.mpos = s.mpos + 5'd1;
						else s.cmatch = 1'b0;
					end
				end else begin
					kind = hrsp_pkg::K_EOL;
					if (r == 2'd2) begin
						if (s.hdr == hrsp_pkg::H_TE) s.chunked = s.cmatch && s.mpos == 5'd7;
						s.phase = hrsp_pkg::PH_HSTART; s.mpos = '0; s.cand = 6'h3F;
						s.hdr = '0; s.saw_cr = 1'b0;
					end
				end
			end
			hrsp_pkg::PH_LEN: begin
				hid = hrsp_pkg::H_LEN;
				if (isdig) begin
					if (s.acc > DEC_LIM || (s.acc == DEC_LIM && dig > DEC_REM)) fail = 1'b1;
					else begin
						s.acc = mul[W-1:0]; kind = hrsp_pkg::K_HVAL;
					end
				end else if (b == hrsp_pkg::CH_CR) begin
					kind = hrsp_pkg::K_EOL; s.phase = hrsp_pkg::PH_LEN_LF;
				end else fail = 1'b1;
			end
			hrsp_pkg::PH_LEN_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_EOL; hid = hrsp_pkg::H_LEN;
					s.rem = s.acc; lv = s.acc; lvalid = 1'b1;
					s.phase = hrsp_pkg::PH_HSTART; s.mpos = '0; s.cand = 6'h3F;
					s.hdr = '0; s.saw_cr = 1'b0;
				end
			end
			hrsp_pkg::PH_BODY, hrsp_pkg::PH_CDATA: begin
				kind = hrsp_pkg::K_BODY; body = b;
				s.rem = s.rem - 1'b1;
				if (s.rem == '0) begin
					if (s.phase == hrsp_pkg::PH_BODY) begin
						done = 1'b1; s.phase = hrsp_pkg::PH_DONE;
					end else begin
						s.first_chunk = 1'b0; s.phase = hrsp_pkg::PH_CCR;
					end
				end
			end
			hrsp_pkg::PH_CSIZE: begin
				kind = hrsp_pkg::K_CHUNK;
				if (b == hrsp_pkg::CH_CR) s.phase = hrsp_pkg::PH_CSIZE_LF;
				else if (!hxok || s.acc[W-1:W-4] != 4'd0) fail = 1'b1;
				else s.acc = {s.acc[W-5:0], hx};
			end
			hrsp_pkg::PH_CSIZE_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_CHUNK; lv = s.acc; lvalid = 1'b1;
					if (s.acc == '0) s.phase = hrsp_pkg::PH_TCR;
					else begin
						s.rem = s.acc; s.phase = hrsp_pkg::PH_CDATA;
					end
				end
			end
			hrsp_pkg::PH_CCR, hrsp_pkg::PH_TCR: begin
				if (b != hrsp_pkg::CH_CR) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_CHUNK;
					s.phase = (s.phase == hrsp_pkg::PH_CCR) ? hrsp_pkg::PH_CLF : hrsp_pkg::PH_TLF;
				end
			end
			hrsp_pkg::PH_CLF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_CHUNK; s.acc = '0; s.phase = hrsp_pkg::PH_CSIZE;
				end
			end
			hrsp_pkg::PH_TLF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1'b1;
				else begin
					kind = hrsp_pkg::K_CHUNK; done = 1'b1; s.phase = hrsp_pkg::PH_DONE;
				end
			end
			hrsp_pkg::PH_DONE: kind = hrsp_pkg::K_IGN;
			default: fail = 1'b1;
		endcase

		if (fail) begin
			s.phase = hrsp_pkg::PH_ERR; kind = hrsp_pkg::K_ERR; hid = '0; body = '0;
			lv = '0; lvalid = 1'b0; done = 1'b0;
		end

		nxt = s;
		res.kind = kind;
		res.hid = hid;
		res.body = body;
		res.code = s.code;
		res.vmaj = s.ver[7:4];
		res.vmin = s.ver[3:0];
		res.lval = lv;
		res.lvalid = lvalid;
		res.done = done;
		res.err = fail;
	end

endmodule

>>> sv/http_response_stream_parser.sv
// ----------------------------------------------------------------------------
// http_response_stream_parser: HTTP/1.x response byte classifier
// Labels every byte of a response stream and extracts status and lengths.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel s_axis_*: one response byte per beat, tuser = start_message
//  (1 restarts parsing with this byte as the first of a new status line).
//  Output channel m_axis_*: exactly one result beat per input beat, in order.
//  The result of a beat is in the output register on the cycle after it
//  is accepted. Throughput: one beat per cycle unless the output stalls; the parser
//  state update is a single combinational step between the input and the
//  output register, so a new byte is taken every cycle while the output drains.
//  Stall: the output register holds while m_axis_tready is low; input is
//  still taken when the register is empty or being drained that same cycle.
//  Reset (arst_n low): state returns to the status line start, output empty.
//  parse_error is sticky until start_message or reset.
// ----------------------------------------------------------------------------
module http_response_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] start_message
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] byte_kind, [5:3] header_id, [13:6] body_byte, [23:14] status_code,
	// [27:24] version_major, [31:28] version_minor, [63:32] length_value,
	// [64] length_valid, [65] message_done, [66] parse_error, [71:67] zero
	output logic [71:0] m_axis_tdata
);

	hrsp_pkg::state_t  st_q, st_nxt;
	hrsp_pkg::result_t res, res_q;
	logic take;

	// a new byte enters whenever the result slot is free or being emptied
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	hrsp_step u_step (
		.cur(st_q), .data_byte(s_axis_tdata), .start_message(s_axis_tuser),
		.nxt(st_nxt), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hrsp_pkg::reset_state();
			m_axis_tvalid <= 1'b0;
		end else begin
			if (take) st_q <= st_nxt;
			if (take) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res;
	end

	assign m_axis_tdata = {5'd0, res_q.err, res_q.done, res_q.lvalid, res_q.lval,
		res_q.vmin, res_q.vmaj, res_q.code, res_q.body, res_q.hid, res_q.kind};

	// error result always carries the error kind
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.err |-> res_q.kind == hrsp_pkg::K_ERR)
		else $error("error flag without error kind");
	// body byte only on body beats
	a_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res_q.kind != hrsp_pkg::K_BODY |-> res_q.body == 8'd0)
		else $error("body byte on non-body beat");
	// error is sticky without restart
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		take && !s_axis_tuser && st_q.phase == hrsp_pkg::PH_ERR |=> res_q.err)
		else $error("error not sticky");

endmodule

>>> tb/http_response_stream_parser_test.sv
// ----------------------------------------------------------------------------
// http_response_stream_parser_test: byte-level check of the response parser
// Feeds directed and random HTTP responses, predicts each result beat with an
// independent parser model and compares all fields in order.
// ----------------------------------------------------------------------------
module http_response_stream_parser_test;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;

	http_response_stream_parser i_dut (.*);

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  hid;
		logic [7:0]  body;
		logic [9:0]  code;
		logic [3:0]  vmaj;
		logic [3:0]  vmin;
		logic [31:0] lval;
		logic        lvalid;
		logic        done;
		logic        err;
	} beat_label_t;

	beat_label_t label_queue[$];
	int  failures;
	int  bytes_sent;
	int  beats_seen;
	int  cycle_count;
	bit  sender_busy_free;  // no idling while set
	bit  sink_busy_free;

	// parser model state
	logic [4:0]  ph;
	logic [4:0]  pos;
	logic [5:0]  cand;
	logic [2:0]  hdr;
	logic [63:0] acc;
	logic [63:0] remain;
	logic        chunked;
	logic        cmatch;
	logic        saw_cr;
	logic [9:0]  code;
	logic [7:0]  ver;

	localparam logic [63:0] LMASK = 64'hFFFF_FFFF;

	function automatic string known_name(int i);
		case (i)
			0: return "Content-Length";
			1: return "Content-Type";
			2: return "Connection";
			3: return "Date";
			4: return "Server";
			default: return "Transfer-Encoding";
		endcase
	endfunction

	function automatic int hexval(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "A" && b <= "F") return b - "A" + 10;
		if (b >= "a" && b <= "f") return b - "a" + 10;
		return -1;
	endfunction

	function automatic logic [7:0] proto_at(logic [4:0] p);
		string s;
		s = "HTTP/";
		return s[p];
	endfunction

	function automatic void model_clear();
		ph = hrsp_pkg::PH_VER; pos = 0; cand = 6'h3F; hdr = 0; acc = 0; remain = 0;
		chunked = 0; cmatch = 1; saw_cr = 0; code = 0; ver = 0;
	endfunction

	function automatic void line_begin();
		ph = hrsp_pkg::PH_HSTART; pos = 0; cand = 6'h3F; hdr = 0; saw_cr = 0;
	endfunction

	// 0 text, 1 CR pending, 2 CR LF complete
	function automatic int crlf_track(logic [7:0] b);
		if (saw_cr) begin
			if (b == hrsp_pkg::CH_LF) begin
				saw_cr = 0;
				return 2;
			end
			cmatch = 0;
			if (b == hrsp_pkg::CH_CR) return 1;
			saw_cr = 0;
			return 0;
		end
		if (b == hrsp_pkg::CH_CR) begin
			saw_cr = 1;
			return 1;
		end
		return 0;
	endfunction

	function automatic beat_label_t label_byte(logic [7:0] b, logic restart);
		beat_label_t r;
		bit fail;
		int sc, h;
		string nm;
		r = '0;
		fail = 0;
		if (restart) model_clear();
		if (ph == hrsp_pkg::PH_SP1 && b != " ") ph = hrsp_pkg::PH_CODE;
		if (ph == hrsp_pkg::PH_SP2 && b != " ") ph = hrsp_pkg::PH_PHRASE;
		if (ph == hrsp_pkg::PH_HSP && b != " ")
			ph = (hdr == hrsp_pkg::H_LEN) ? hrsp_pkg::PH_LEN : hrsp_pkg::PH_HVAL;
		if (ph == hrsp_pkg::PH_HSTART && b != hrsp_pkg::CH_CR) ph = hrsp_pkg::PH_HNAME;
		case (ph)
			hrsp_pkg::PH_VER: begin
				if (pos < 5) fail = (b != proto_at(pos));
				else if (pos == 6) fail = (b != ".");
				else if (b < "0" || b > "9") fail = 1;
				else if (pos == 5) ver = {b[3:0], 4'd0};
				else begin
					ver[3:0] = b[3:0];
					ph = hrsp_pkg::PH_SP1;
				end
				pos++;
				if (ph == hrsp_pkg::PH_SP1) begin
					pos = 0;
					acc = 0;
				end
			end
			hrsp_pkg::PH_SP1, hrsp_pkg::PH_SP2: ;
			hrsp_pkg::PH_CODE: begin
				if (b < "0" || b > "9") fail = 1;
				else begin
					acc = acc * 10 + (b - "0");
					pos++;
					if (pos >= 3) begin
						code = acc[9:0];
						acc = 0; pos = 0; saw_cr = 0;
						ph = hrsp_pkg::PH_SP2;
					end
				end
			end
			hrsp_pkg::PH_PHRASE: begin
				sc = crlf_track(b);
				if (sc != 0) r.kind = hrsp_pkg::K_EOL;
				if (sc == 2) line_begin();
			end
			hrsp_pkg::PH_HSTART: begin
				r.kind = hrsp_pkg::K_EOL;
				ph = hrsp_pkg::PH_HEND_LF;
			end
			hrsp_pkg::PH_HEND_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_EOL;
					if (chunked) begin
						remain = 0; acc = 0; ph = hrsp_pkg::PH_CSIZE;
					end else if (remain == 0) begin
						r.done = 1; ph = hrsp_pkg::PH_DONE;
					end else ph = hrsp_pkg::PH_BODY;
				end
			end
			hrsp_pkg::PH_HNAME: begin
				r.kind = hrsp_pkg::K_HNAME;
				if (b == ":") begin
					hdr = 0;
					for (int i = 0; i < 6; i++)
						if (cand[i] && known_name(i).len() == pos) hdr = 3'(i + 1);
					r.hid = hdr;
					acc = 0; pos = 0; cmatch = 1; saw_cr = 0;
					ph = hrsp_pkg::PH_HSP;
				end else if (b == hrsp_pkg::CH_CR || b == hrsp_pkg::CH_LF) fail = 1;
				else begin
					for (int i = 0; i < 6; i++) begin
						nm = known_name(i);
						if (pos >= nm.len() || nm[pos] != b) cand[i] = 0;
					end
					if (pos < 31) pos++;
				end
			end
			hrsp_pkg::PH_HSP: begin
				r.kind = hrsp_pkg::K_HVAL;
				r.hid = hdr;
			end
			hrsp_pkg::PH_HVAL: begin
				r.hid = hdr;
				sc = crlf_track(b);
				if (sc == 0) begin
					r.kind = hrsp_pkg::K_HVAL;
					if (hdr == hrsp_pkg::H_TE) begin
						nm = "chunked";
						if (pos < 7 && b == nm[pos]) pos++;
						else cmatch = 0;
					end
				end else begin
					r.kind = hrsp_pkg::K_EOL;
					if (sc == 2) begin
						if (hdr == hrsp_pkg::H_TE) chunked = cmatch && pos == 7;
						line_begin();
					end
				end
			end
			hrsp_pkg::PH_LEN: begin
				r.hid = hrsp_pkg::H_LEN;
				if (b >= "0" && b <= "9") begin
					if (acc > (LMASK - (b - "0")) / 10) fail = 1;
					else begin
						acc = acc * 10 + (b - "0");
						r.kind = hrsp_pkg::K_HVAL;
					end
				end else if (b == hrsp_pkg::CH_CR) begin
					r.kind = hrsp_pkg::K_EOL;
					ph = hrsp_pkg::PH_LEN_LF;
				end else fail = 1;
			end
			hrsp_pkg::PH_LEN_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_EOL; r.hid = hrsp_pkg::H_LEN;
					remain = acc; r.lval = acc[31:0]; r.lvalid = 1;
					line_begin();
				end
			end
			hrsp_pkg::PH_BODY, hrsp_pkg::PH_CDATA: begin
				r.kind = hrsp_pkg::K_BODY;
				r.body = b;
				remain = (remain - 1) & LMASK;
				if (remain == 0) begin
					if (ph == hrsp_pkg::PH_BODY) begin
						r.done = 1; ph = hrsp_pkg::PH_DONE;
					end else ph = hrsp_pkg::PH_CCR;
				end
			end
			hrsp_pkg::PH_CSIZE: begin
				r.kind = hrsp_pkg::K_CHUNK;
				if (b == hrsp_pkg::CH_CR) ph = hrsp_pkg::PH_CSIZE_LF;
				else begin
					h = hexval(b);
					if (h < 0 || acc > (LMASK >> 4)) fail = 1;
					else acc = (acc << 4) | 64'(h);
				end
			end
			hrsp_pkg::PH_CSIZE_LF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_CHUNK; r.lval = acc[31:0]; r.lvalid = 1;
					if (acc == 0) ph = hrsp_pkg::PH_TCR;
					else begin
						remain = acc; ph = hrsp_pkg::PH_CDATA;
					end
				end
			end
			hrsp_pkg::PH_CCR, hrsp_pkg::PH_TCR: begin
				if (b != hrsp_pkg::CH_CR) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_CHUNK;
					ph = (ph == hrsp_pkg::PH_CCR) ? hrsp_pkg::PH_CLF : hrsp_pkg::PH_TLF;
				end
			end
			hrsp_pkg::PH_CLF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_CHUNK; acc = 0; ph = hrsp_pkg::PH_CSIZE;
				end
			end
			hrsp_pkg::PH_TLF: begin
				if (b != hrsp_pkg::CH_LF) fail = 1;
				else begin
					r.kind = hrsp_pkg::K_CHUNK; r.done = 1; ph = hrsp_pkg::PH_DONE;
				end
			end
			hrsp_pkg::PH_DONE: r.kind = hrsp_pkg::K_IGN;
			default: fail = 1;
		endcase
		if (fail) begin
			ph = hrsp_pkg::PH_ERR;
			r = '0;
			r.kind = hrsp_pkg::K_ERR;
			r.err = 1;
		end
		r.code = code;
		r.vmaj = ver[7:4];
		r.vmin = ver[3:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// -------------------------------------------------------------- sending
	// tvalid stays up across back-to-back beats and drops only while idling
	task automatic send_byte(logic [7:0] b, logic restart = 0);
		while (!sender_busy_free && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= restart;
		label_queue.push_back(label_byte(b, restart));
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_text(string s, logic restart = 0);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], restart && i == 0);
	endtask

	task automatic drain_labels();
		s_axis_tvalid <= 0;
		while (label_queue.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------- checking
	always @(posedge clk) begin
		if (arst_n) m_axis_tready <= sink_busy_free || $urandom_range(99) >= 21;
	end

	always @(posedge clk) begin
		beat_label_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[13:6],
				m_axis_tdata[23:14], m_axis_tdata[27:24], m_axis_tdata[31:28],
				m_axis_tdata[63:32], m_axis_tdata[64], m_axis_tdata[65], m_axis_tdata[66]};
			beats_seen++;
			if (label_queue.size() == 0) begin
				$error("result beat with nothing expected");
				failures++;
			end else begin
				want = label_queue.pop_front();
				if (got.kind != want.kind) begin
					$error("byte_kind exp %0d got %0d", want.kind, got.kind); failures++;
				end
				if (got.hid != want.hid) begin
					$error("header_id exp %0d got %0d", want.hid, got.hid); failures++;
				end
				if (got.body != want.body) begin
					$error("body_byte exp %0h got %0h", want.body, got.body); failures++;
				end
				if (got.code != want.code) begin
					$error("status_code exp %0d got %0d", want.code, got.code); failures++;
				end
				if (got.vmaj != want.vmaj) begin
					$error("version_major exp %0d got %0d", want.vmaj, got.vmaj); failures++;
				end
				if (got.vmin != want.vmin) begin
					$error("version_minor exp %0d got %0d", want.vmin, got.vmin); failures++;
				end
				if (got.lval != want.lval) begin
					$error("length_value exp %0d got %0d", want.lval, got.lval); failures++;
				end
				if (got.lvalid != want.lvalid) begin
					$error("length_valid exp %0d got %0d", want.lvalid, got.lvalid); failures++;
				end
				if (got.done != want.done) begin
					$error("message_done exp %0d got %0d", want.done, got.done); failures++;
				end
				if (got.err != want.err) begin
					$error("parse_error exp %0d got %0d", want.err, got.err); failures++;
				end
			end
		end
	end

	// -------------------------------------------------------- random pieces
	function automatic string rand_text(int n);
		string s;
		s = "";
		for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 126)))};
		return s;
	endfunction

	function automatic string hex_of(int unsigned v);
		return $sformatf("%0h", v);
	endfunction

	function automatic string status_line();
		return $sformatf("HTTP/%0d.%0d%s%0d%0d%0d%s%s\r\n", $urandom_range(9), $urandom_range(9),
			($urandom_range(1) ? " " : ""), $urandom_range(9), $urandom_range(9),
			$urandom_range(9), ($urandom_range(1) ? " " : ""), rand_text($urandom_range(0, 4)));
	endfunction

	// mostly well-formed response with random headers and body framing
	task automatic random_response();
		int blen, nch, cl;
		bit chk;
		string s;
		chk = $urandom_range(2) == 0;
		blen = $urandom_range(0, 12);
		s = status_line();
		if ($urandom_range(1)) s = {s, "Date: ", rand_text(3), "\r\n"};
		if ($urandom_range(1)) s = {s, "X-", rand_text(2), ": v\r\n"};
		if ($urandom_range(3) == 0) s = {s, "Server:\r\n"};
		if (chk) s = {s, "Transfer-Encoding: chunked\r\n"};
		else if ($urandom_range(3) != 0) s = {s, $sformatf("Content-Length: %0d\r\n", blen)};
		else blen = 0;
		s = {s, "\r\n"};
		if (chk) begin
			nch = $urandom_range(0, 2);
			for (int i = 0; i < nch; i++) begin
				cl = $urandom_range(1, 6);
				s = {s, ($urandom_range(1) ? hex_of(cl) : $sformatf("%0H", cl)), "\r\n",
					rand_text(cl), "\r\n"};
			end
			s = {s, "0\r\n\r\n"};
		end else begin
			for (int i = 0; i < blen; i++) s = {s, string'(8'($urandom_range(255)))};
		end
		// sometimes corrupt one byte
		if ($urandom_range(9) == 0) s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
		send_text(s, 1);
		if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_status_line();
		send_text("HTTP/1.1 200 OK\r\n\r\n", 1);
		send_text("HTTP/9.0999\r\n\r\n", 1);
		send_text("HTTP/1.1 2x0 OK\r\n", 1);   // non-digit code
		send_text("HTTQ/1.1", 1);
		send_text("HTTP/a", 1);
		send_text("HTTP/1,1", 1);
	endtask

	task automatic test_headers();
		send_text({"HTTP/1.0 404 N\rx\n\r\nContent-Type: a\rb\r\nConnection:c\r\n",
			"Server: s\r\nDate: d\r\ncontent-length: 3\r\nContent-Length: 2\r\n\r\nab!!"}, 1);
		send_text("HTTP/1.1 200 \r\nBad\rName", 1);
		send_text("HTTP/1.1 200 \r\n\n", 1);
		send_text("HTTP/1.1 200 \r\n\rX", 1);
		send_text("HTTP/1.1 200 \r\nContent-Length: 5 \r\n", 1);
		send_text("HTTP/1.1 200 \r\nContent-Length:\r\n\r\n", 1);
		send_text("HTTP/1.1 200 \r\nContent-Length: 4294967295\r\n", 1);
		send_text("HTTP/1.1 200 \r\nContent-Length: 4294967296\r\n", 1);
	endtask

	task automatic test_chunked();
		send_text({"HTTP/1.1 200 \r\nContent-Length: 9\r\nTransfer-Encoding: chunked\r\n",
			"\r\n3\r\nabc\r\naF\r\n0123456789\r\r\n"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunked\r\n\r\n",
			"2\r\nxy\r\n\r\n\r\n"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunkedx\r\n",
			"Transfer-Encoding: chu\rnked\r\n\r\nz"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunked\r\n\r\n",
			"FFFFFFFF0\r\n"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunked\r\n\r\n",
			"1;x\r\n"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunked\r\n\r\n",
			"1\r\nqX"}, 1);
		send_text({"HTTP/1.1 200 \r\nTransfer-Encoding: chunked\r\n\r\n",
			"0\r\nT"}, 1);
	endtask

	// tops the run up to about 1100 bytes in total
	task automatic test_random_responses();
		int stop_at;
		stop_at = 1100;
		while (bytes_sent < stop_at) begin
			random_response();
			if ($urandom_range(19) == 0) begin
				// raw noise, every bit pattern
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
	endtask

	task automatic test_no_idle_stretch();
		sender_busy_free = 1;
		sink_busy_free = 1;
		repeat (6) random_response();
		sender_busy_free = 0;
		sink_busy_free = 0;
	endtask

	// ----------------------------------------------------------------- main
	initial begin
		int limit;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		failures = 0;
		bytes_sent = 0;
		beats_seen = 0;
		cycle_count = 0;
		sender_busy_free = 0;
		sink_busy_free = 0;
		model_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_status_line();
		test_headers();
		drain_labels();  // sender holds until every result is back
		test_chunked();
		test_no_idle_stretch();
		test_random_responses();
		s_axis_tvalid <= 0;
		limit = cycle_count + 20000;
		while (label_queue.size() != 0 && cycle_count < limit) @(posedge clk);
		repeat (4) @(posedge clk);
		if (label_queue.size() != 0) begin
			$display("%0d results never arrived", label_queue.size());
			failures++;
		end
		$display("Covered %0d bytes: status lines, known and unknown headers,", bytes_sent);
		$display("length and chunked bodies, overflow and broken framing; %0d beats checked.",
			beats_seen);
		if (failures == 0) begin
			$display("PASS http_response_stream_parser");
		end else begin
			$display("FAIL http_response_stream_parser");
		end
		$finish;
	end

	// hard stop
	initial begin
		wait (cycle_count > 400000);
		$display("FAIL http_response_stream_parser");
		$finish;
	end

endmodule
